/* rtl/hjc_pkg.sv */
// Shared types, constants and jamo lookup functions for the Hangul jamo composer.
package hjc_pkg;

	// Item kinds carried in tuser.
	localparam logic MODE_CHAR  = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	// Code point ranges and syllable geometry.
	localparam logic [15:0] SYL_BASE = 16'hAC00;
	localparam logic [15:0] SYL_END  = 16'hD7A4;
	localparam logic [15:0] VOW_BASE = 16'h314F;
	localparam logic [15:0] VOW_END  = 16'h3163;
	localparam logic [15:0] JAMO_LO  = 16'h3131;
	localparam logic [15:0] JAMO_HI  = 16'h3163;
	localparam logic [15:0] NUM_V    = 16'd21;
	localparam logic [15:0] NUM_T    = 16'd28;
	localparam logic [15:0] NUM_VT   = 16'd588;

	// Reciprocal constants: s / 588 = (s * RECIP_L) >> 24, s / 28 = (s * RECIP_Q) >> 20
	// for every syllable offset s below 11172.
	localparam logic [28:0] RECIP_L = 29'd28533;
	localparam logic [29:0] RECIP_Q = 30'd37450;

	// Index lookup result.
	typedef struct packed {
		logic       ok;
		logic [4:0] idx;
	} idx_t;

	// Split of a final consonant when a vowel follows: the final kept on the
	// emitted syllable and the initial that starts the new one.
	typedef struct packed {
		logic       ok;
		logic [4:0] keep_t;
		logic [4:0] lead;
	} split_t;

	// Decoded view of one character.
	typedef struct packed {
		logic [15:0] code;
		logic        is_syl;
		logic        is_jamo;
		logic        is_vowel;
		logic [4:0]  l;
		logic [4:0]  v;
		logic [4:0]  t;
		logic [4:0]  vow;
		logic        lead_ok;
		logic [4:0]  lead;
		logic [4:0]  tail;
	} char_info_t;

	// One decoded input transaction.
	typedef struct packed {
		logic       mode;
		char_info_t info;
	} item_t;

	// Result of the compose stage toward the output register.
	typedef struct packed {
		logic        emit;
		logic [15:0] code;
	} result_t;

	// Initial consonant index of a compatibility jamo.
	function automatic idx_t lead_idx(input logic [15:0] c);
		idx_t r;
		r.ok = 1'b1;
		case (c)
			16'h3131: r.idx = 5'd0;
			16'h3132: r.idx = 5'd1;
			16'h3134: r.idx = 5'd2;
			16'h3137: r.idx = 5'd3;
			16'h3138: r.idx = 5'd4;
			16'h3139: r.idx = 5'd5;
			16'h3141: r.idx = 5'd6;
			16'h3142: r.idx = 5'd7;
			16'h3143: r.idx = 5'd8;
			16'h3145: r.idx = 5'd9;
			16'h3146: r.idx = 5'd10;
			16'h3147: r.idx = 5'd11;
			16'h3148: r.idx = 5'd12;
			16'h3149: r.idx = 5'd13;
			16'h314A: r.idx = 5'd14;
			16'h314B: r.idx = 5'd15;
			16'h314C: r.idx = 5'd16;
			16'h314D: r.idx = 5'd17;
			16'h314E: r.idx = 5'd18;
			default: begin
				r.ok  = 1'b0;
				r.idx = 5'd0;
			end
		endcase
		return r;
	endfunction

	// Final consonant index of a compatibility jamo; zero when it is no final.
	function automatic logic [4:0] tail_idx(input logic [15:0] c);
		logic [4:0] r;
		case (c)
			16'h3131: r = 5'd1;
			16'h3132: r = 5'd2;
			16'h3133: r = 5'd3;
			16'h3134: r = 5'd4;
			16'h3135: r = 5'd5;
			16'h3136: r = 5'd6;
			16'h3137: r = 5'd7;
			16'h3139: r = 5'd8;
			16'h313A: r = 5'd9;
			16'h313B: r = 5'd10;
			16'h313C: r = 5'd11;
			16'h313D: r = 5'd12;
			16'h313E: r = 5'd13;
			16'h313F: r = 5'd14;
			16'h3140: r = 5'd15;
			16'h3141: r = 5'd16;
			16'h3142: r = 5'd17;
			16'h3144: r = 5'd18;
			16'h3145: r = 5'd19;
			16'h3146: r = 5'd20;
			16'h3147: r = 5'd21;
			16'h3148: r = 5'd22;
			16'h314A: r = 5'd23;
			16'h314B: r = 5'd24;
			16'h314C: r = 5'd25;
			16'h314D: r = 5'd26;
			16'h314E: r = 5'd27;
			default:  r = 5'd0;
		endcase
		return r;
	endfunction

	// Compound vowel formed by vowel a followed by vowel b.
	function automatic idx_t vow_join(input logic [4:0] a, input logic [4:0] b);
		idx_t r;
		r.ok = 1'b1;
		case ({a, b})
			{5'd8, 5'd0}:   r.idx = 5'd9;
			{5'd8, 5'd1}:   r.idx = 5'd10;
			{5'd8, 5'd20}:  r.idx = 5'd11;
			{5'd13, 5'd4}:  r.idx = 5'd14;
			{5'd13, 5'd5}:  r.idx = 5'd15;
			{5'd13, 5'd20}: r.idx = 5'd16;
			{5'd18, 5'd20}: r.idx = 5'd19;
			default: begin
				r.ok  = 1'b0;
				r.idx = 5'd0;
			end
		endcase
		return r;
	endfunction

	// Compound final formed by final a followed by final b.
	function automatic idx_t fin_join(input logic [4:0] a, input logic [4:0] b);
		idx_t r;
		r.ok = 1'b1;
		case ({a, b})
			{5'd1, 5'd19}:  r.idx = 5'd3;
			{5'd4, 5'd22}:  r.idx = 5'd5;
			{5'd4, 5'd27}:  r.idx = 5'd6;
			{5'd8, 5'd1}:   r.idx = 5'd9;
			{5'd8, 5'd16}:  r.idx = 5'd10;
			{5'd8, 5'd17}:  r.idx = 5'd11;
			{5'd8, 5'd19}:  r.idx = 5'd12;
			{5'd8, 5'd25}:  r.idx = 5'd13;
			{5'd8, 5'd26}:  r.idx = 5'd14;
			{5'd8, 5'd27}:  r.idx = 5'd15;
			{5'd17, 5'd19}: r.idx = 5'd18;
			{5'd19, 5'd19}: r.idx = 5'd20;
			default: begin
				r.ok  = 1'b0;
				r.idx = 5'd0;
			end
		endcase
		return r;
	endfunction

	// How a final moves into the next syllable when a vowel follows.
	// A final that is also an initial moves whole; a compound final leaves
	// its first half behind and moves its second half.
	function automatic split_t tail_split(input logic [4:0] t);
		split_t r;
		r.ok     = 1'b1;
		r.keep_t = 5'd0;
		case (t)
			5'd1:  r.lead = 5'd0;
			5'd2:  r.lead = 5'd1;
			5'd3:  begin r.keep_t = 5'd1;  r.lead = 5'd9;  end
			5'd4:  r.lead = 5'd2;
			5'd5:  begin r.keep_t = 5'd4;  r.lead = 5'd12; end
			5'd6:  begin r.keep_t = 5'd4;  r.lead = 5'd18; end
			5'd7:  r.lead = 5'd3;
			5'd8:  r.lead = 5'd5;
			5'd9:  begin r.keep_t = 5'd8;  r.lead = 5'd0;  end
			5'd10: begin r.keep_t = 5'd8;  r.lead = 5'd6;  end
			5'd11: begin r.keep_t = 5'd8;  r.lead = 5'd7;  end
			5'd12: begin r.keep_t = 5'd8;  r.lead = 5'd9;  end
			5'd13: begin r.keep_t = 5'd8;  r.lead = 5'd16; end
			5'd14: begin r.keep_t = 5'd8;  r.lead = 5'd17; end
			5'd15: begin r.keep_t = 5'd8;  r.lead = 5'd18; end
			5'd16: r.lead = 5'd6;
			5'd17: r.lead = 5'd7;
			5'd18: begin r.keep_t = 5'd17; r.lead = 5'd9;  end
			5'd19: r.lead = 5'd9;
			5'd20: r.lead = 5'd10;
			5'd21: r.lead = 5'd11;
			5'd22: r.lead = 5'd12;
			5'd23: r.lead = 5'd14;
			5'd24: r.lead = 5'd15;
			5'd25: r.lead = 5'd16;
			5'd26: r.lead = 5'd17;
			5'd27: r.lead = 5'd18;
			default: begin
				r.ok   = 1'b0;
				r.lead = 5'd0;
			end
		endcase
		return r;
	endfunction

	// Code point of the syllable with initial l, vowel v and final t.
	function automatic logic [15:0] syl_char(input logic [4:0] l, input logic [4:0] v,
			input logic [4:0] t);
		return SYL_BASE + 16'(l) * NUM_VT + 16'(v) * NUM_T + 16'(t);
	endfunction

endpackage

/* rtl/hjc_decode.sv */
// Input register and character decode stage of the Hangul jamo composer.
module hjc_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           in_mode,
	input  logic [15:0]    in_code,
	input  logic           down_ready,
	output logic           item_valid,
	output hjc_pkg::item_t item
);
	import hjc_pkg::*;

	logic        valid_s1;
	logic        mode_s1;
	logic [15:0] code_s1;
	logic        valid_s2;
	item_t       item_s2;
	logic        ready_s2;

	logic [15:0] diff;
	logic [13:0] s;
	logic [28:0] prod_l;
	logic [29:0] prod_q;
	logic [4:0]  l_div;
	logic [8:0]  q28;
	logic [8:0]  v_tmp;
	logic [13:0] t_tmp;
	idx_t        lead_r;
	char_info_t  info;

	// A stage can load when it is empty or when its contents move on.
	assign ready_s2 = !valid_s2 || down_ready;
	assign in_ready = !valid_s1 || ready_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= in_mode;
			code_s1 <= in_code;
		end
	end

	// Split a syllable offset into initial, vowel and final by reciprocal
	// multiplication, and look up the jamo indexes.
	always_comb begin
		diff   = code_s1 - SYL_BASE;
		s      = diff[13:0];
		prod_l = 29'(s) * RECIP_L;
		prod_q = 30'(s) * RECIP_Q;
		l_div  = prod_l[28:24];
		q28    = prod_q[28:20];
		v_tmp  = q28 - 9'(l_div) * 9'(NUM_V);
		t_tmp  = s - 14'(q28) * 14'(NUM_T);
		lead_r = lead_idx(code_s1);

		info.code     = code_s1;
		info.is_syl   = (code_s1 >= SYL_BASE) && (code_s1 < SYL_END);
		info.is_jamo  = (code_s1 >= JAMO_LO) && (code_s1 <= JAMO_HI);
		info.is_vowel = (code_s1 >= VOW_BASE) && (code_s1 <= VOW_END);
		info.l        = info.is_syl ? l_div : 5'd0;
		info.v        = info.is_syl ? v_tmp[4:0] : 5'd0;
		info.t        = info.is_syl ? t_tmp[4:0] : 5'd0;
		info.vow      = 5'(code_s1 - VOW_BASE);
		info.lead_ok  = lead_r.ok;
		info.lead     = lead_r.idx;
		info.tail     = tail_idx(code_s1);
	end

	// Decoded register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			item_s2.mode <= mode_s1;
			item_s2.info <= info;
		end
	end

	assign item_valid = valid_s2;
	assign item       = item_s2;

endmodule

/* rtl/hjc_compose.sv */
// Held character register and composition rules of the Hangul jamo composer.
module hjc_compose (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  hjc_pkg::item_t   item,
	output hjc_pkg::result_t res
);
	import hjc_pkg::*;

	logic       held_valid_q;
	char_info_t held_q;

	char_info_t u;
	char_info_t nh;
	char_info_t joined;
	logic       nh_valid;
	logic       join_ok;
	logic       split;
	logic [4:0] split_t_val;
	idx_t       fin_r;
	idx_t       vow_r;
	split_t     spl;

	// Evaluate the join of the incoming jamo onto the held character.
	always_comb begin
		u           = item.info;
		fin_r       = fin_join(held_q.t, u.tail);
		vow_r       = vow_join(held_q.v, u.vow);
		spl         = tail_split(held_q.t);
		join_ok     = 1'b0;
		split       = 1'b0;
		split_t_val = held_q.t;
		joined      = '0;
		joined.is_syl = 1'b1;
		joined.l    = held_q.l;
		joined.v    = held_q.v;
		joined.t    = held_q.t;

		if (u.is_jamo) begin
			if (held_q.is_syl) begin
				if (held_q.t == 5'd0) begin
					// Open syllable: take a final, or widen the vowel.
					if (u.tail != 5'd0) begin
						join_ok  = 1'b1;
						joined.t = u.tail;
					end else if (u.is_vowel && vow_r.ok) begin
						join_ok  = 1'b1;
						joined.v = vow_r.idx;
					end
				end else if (u.is_vowel) begin
					// Closed syllable and a vowel: the final, or its second half, starts a new syllable.
					if (spl.ok) begin
						join_ok     = 1'b1;
						split       = 1'b1;
						split_t_val = spl.keep_t;
						joined.l    = spl.lead;
						joined.v    = u.vow;
						joined.t    = 5'd0;
					end
				end else if (u.tail != 5'd0 && fin_r.ok) begin
					// Closed syllable and a consonant: form a compound final.
					join_ok  = 1'b1;
					joined.t = fin_r.idx;
				end
			end else if (held_q.lead_ok && u.is_vowel) begin
				// Initial consonant and a vowel make an open syllable.
				join_ok  = 1'b1;
				joined.l = held_q.lead;
				joined.v = u.vow;
				joined.t = 5'd0;
			end
		end
		joined.code = syl_char(joined.l, joined.v, joined.t);
	end

	// Choose the next held character and the result for this transaction.
	always_comb begin
		res.emit = 1'b0;
		res.code = held_q.code;
		nh       = held_q;
		nh_valid = held_valid_q;
		if (fire) begin
			if (item.mode == MODE_FLUSH) begin
				if (held_valid_q) begin
					res.emit = 1'b1;
					nh       = '0;
					nh_valid = 1'b0;
				end
			end else if (!held_valid_q) begin
				nh       = u;
				nh_valid = 1'b1;
			end else if (join_ok) begin
				nh = joined;
				if (split) begin
					res.emit = 1'b1;
					res.code = syl_char(held_q.l, held_q.v, split_t_val);
				end
			end else begin
				res.emit = 1'b1;
				nh       = u;
			end
		end
	end

	// Held character state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_q       <= '0;
		end else begin
			held_valid_q <= nh_valid;
			held_q       <= nh;
		end
	end

	// A flush always leaves nothing held.
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == MODE_FLUSH |=> !held_valid_q)
		else $error("held character survived a flush");

	// A character transaction always leaves a character held.
	a_char_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == MODE_CHAR |=> held_valid_q)
		else $error("character transaction left nothing held");

	// A result only ever comes from a held character.
	a_emit_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit |-> held_valid_q && fire)
		else $error("result emitted with nothing held");

endmodule

/* rtl/hangul_jamo_composer_core.sv */
// Top level of the Hangul jamo composer: stream ports, decode, compose and output register.
//
// Channel  Direction  Beat contents
// s_axis   in         tdata = char_in[15:0]; tuser = mode (0 character, 1 flush)
// m_axis   out        tdata = char_out[15:0]
//
// One transaction is accepted per cycle while no stage is stalled. Each one passes through
// the input and decode registers, and any result it composes loads the output register.
// The syllable split in the decode stage uses two constant reciprocal multipliers.
// Reset clears all valid bits and the held character; nothing is held after reset.
// A stalled output holds its result; the input keeps accepting until every stage is full.
module hangul_jamo_composer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] char_in
	input  logic        s_axis_tuser,  // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [15:0] char_out
);
	import hjc_pkg::*;

	logic        out_valid_q;
	logic [15:0] out_data_q;
	logic        out_ready;
	logic        item_valid;
	item_t       item;
	logic        fire;
	result_t     res;

	hjc_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_mode    (s_axis_tuser),
		.in_code    (s_axis_tdata),
		.down_ready (out_ready),
		.item_valid (item_valid),
		.item       (item)
	);

	hjc_compose u_compose (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item),
		.res    (res)
	);

	// The compose stage runs when the output register is free or being drained.
	assign out_ready = !out_valid_q || m_axis_tready;
	assign fire      = item_valid && out_ready;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= res.emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.emit) begin
			out_data_q <= res.code;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the Hangul jamo composer core with a built-in composition predictor.
`timescale 1ns / 100ps

module testbench;
	import hjc_pkg::*;

	localparam int N_V = 21;
	localparam int N_T = 28;
	localparam int EXP_DEPTH = 256;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;  // [15:0] char_in
	logic        s_axis_tuser;  // [0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;  // [15:0] char_out

	// Initial consonants in index order, finals in index order (index 0 is no final).
	logic [15:0] lead_codes [19] = '{
		16'h3131, 16'h3132, 16'h3134, 16'h3137, 16'h3138, 16'h3139, 16'h3141,
		16'h3142, 16'h3143, 16'h3145, 16'h3146, 16'h3147, 16'h3148, 16'h3149,
		16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E};
	logic [15:0] tail_codes [28] = '{
		16'h0000, 16'h3131, 16'h3132, 16'h3133, 16'h3134, 16'h3135, 16'h3136,
		16'h3137, 16'h3139, 16'h313A, 16'h313B, 16'h313C, 16'h313D, 16'h313E,
		16'h313F, 16'h3140, 16'h3141, 16'h3142, 16'h3144, 16'h3145, 16'h3146,
		16'h3147, 16'h3148, 16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E};

	// Compound vowels: first vowel, second vowel, resulting vowel.
	int vp_a [7] = '{8, 8, 8, 13, 13, 13, 18};
	int vp_b [7] = '{0, 1, 20, 4, 5, 20, 20};
	int vp_d [7] = '{9, 10, 11, 14, 15, 16, 19};

	// Compound finals: first final, second final, resulting final.
	int fp_a [12] = '{1, 4, 4, 8, 8, 8, 8, 8, 8, 8, 17, 19};
	int fp_b [12] = '{19, 22, 27, 1, 16, 17, 19, 25, 26, 27, 19, 19};
	int fp_d [12] = '{3, 5, 6, 9, 10, 11, 12, 13, 14, 15, 18, 20};

	// Predictor state and a ring of the characters expected on the output.
	logic [15:0] held_code;
	logic        held_busy;
	logic [15:0] exp_mem [EXP_DEPTH];
	int          exp_head;
	int          exp_tail;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int n_sent;
	int n_flushes;
	int n_splits;
	int n_received;
	int n_errors;

	hangul_jamo_composer_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Number of characters predicted but not yet seen on the output.
	function automatic int expected_count();
		return exp_tail - exp_head;
	endfunction

	// Appends one predicted character to the ring.
	function automatic void store_expected(input logic [15:0] c);
		exp_mem[exp_tail % EXP_DEPTH] = c;
		exp_tail++;
	endfunction

	// Safety net in case the block stops moving.
	initial begin
		#2_000_000;
		$display("Timeout with %0d characters still expected.", expected_count());
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int lead_of(input logic [15:0] c);
		for (int i = 0; i < 19; i++)
			if (lead_codes[i] == c) return i;
		return -1;
	endfunction

	function automatic int tail_of(input logic [15:0] c);
		for (int i = 1; i < 28; i++)
			if (tail_codes[i] == c) return i;
		return 0;
	endfunction

	function automatic logic [15:0] lv_code(input int l, input int v);
		return 16'(SYL_BASE + (l * N_V + v) * N_T);
	endfunction

	// Tries to join jamo u to held character h. Returns 1 when they join; split
	// marks the case where a final moves into a new syllable and emit is pushed out.
	function automatic bit try_join(input logic [15:0] h, input logic [15:0] u,
			output logic [15:0] nh, output bit split, output logic [15:0] emit);
		int s;
		int t;
		int va;
		int f;
		int l;
		int lb;
		int fb;
		bit vowel;
		split = 1'b0;
		nh    = 16'h0000;
		emit  = 16'h0000;
		vowel = (u >= VOW_BASE) && (u <= VOW_END);
		if (h >= SYL_BASE && h < SYL_END) begin
			s = h - SYL_BASE;
			t = s % N_T;
			if (t == 0) begin
				// Open syllable: take a final, or build a compound vowel.
				f = tail_of(u);
				if (f != 0) begin
					nh = 16'(h + f);
					return 1'b1;
				end
				if (vowel) begin
					va = (s % (N_V * N_T)) / N_T;
					for (int i = 0; i < 7; i++)
						if (vp_a[i] == va && vp_b[i] == int'(u - VOW_BASE)) begin
							nh = 16'(h - va * N_T + vp_d[i] * N_T);
							return 1'b1;
						end
				end
				return 1'b0;
			end
			if (vowel) begin
				// Closed syllable and a vowel: the final, or its second half, moves on.
				l = lead_of(tail_codes[t]);
				if (l >= 0) begin
					emit  = 16'(h - t);
					nh    = lv_code(l, u - VOW_BASE);
					split = 1'b1;
					return 1'b1;
				end
				for (int i = 0; i < 12; i++)
					if (fp_d[i] == t) begin
						lb = lead_of(tail_codes[fp_b[i]]);
						if (lb < 0) lb = 0;
						emit  = 16'(h - t + fp_a[i]);
						nh    = lv_code(lb, u - VOW_BASE);
						split = 1'b1;
						return 1'b1;
					end
				return 1'b0;
			end
			// Closed syllable and a consonant: only a compound final joins.
			fb = tail_of(u);
			if (fb == 0) return 1'b0;
			for (int i = 0; i < 12; i++)
				if (fp_a[i] == t && fp_b[i] == fb) begin
					nh = 16'(h - t + fp_d[i]);
					return 1'b1;
				end
			return 1'b0;
		end
		// Lone initial consonant followed by a vowel.
		l = lead_of(h);
		if (l >= 0 && vowel) begin
			nh = lv_code(l, u - VOW_BASE);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advances the predictor by one accepted transaction.
	function automatic void compose_char(input logic m, input logic [15:0] c);
		logic [15:0] nh;
		logic [15:0] em;
		bit          sp;
		if (m == MODE_FLUSH) begin
			n_flushes++;
			if (held_busy) begin
				store_expected(held_code);
				held_code = 16'h0000;
				held_busy = 1'b0;
			end
			return;
		end
		if (!held_busy) begin
			held_code = c;
			held_busy = 1'b1;
			return;
		end
		if (c >= JAMO_LO && c <= JAMO_HI && try_join(held_code, c, nh, sp, em)) begin
			held_code = nh;
			if (sp) begin
				store_expected(em);
				n_splits++;
			end
			return;
		end
		store_expected(held_code);
		held_code = c;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		n_errors++;
		$display("Mismatch at %0t ns: %s, got %h, expected %h", $time, what, got, want);
	endtask

	// Offers one transaction after a random idle gap and waits until it is taken.
	task automatic send_char(input logic m, input logic [15:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= m;
		s_axis_tdata  <= c;
		do @(posedge clk); while (!s_axis_tready);
		compose_char(m, c);
		n_sent++;
	endtask

	// Stops offering until every expected character has come out.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_count() != 0);
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Output checker: each output transaction against the oldest expectation.
	initial begin
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				n_received++;
				if (expected_count() == 0) begin
					report_mismatch("unexpected character", m_axis_tdata, 16'h0000);
				end else begin
					if (m_axis_tdata != exp_mem[exp_head % EXP_DEPTH])
						report_mismatch("char_out", m_axis_tdata,
							exp_mem[exp_head % EXP_DEPTH]);
					exp_head++;
				end
			end
		end
	end

	// Hand-picked sequence through every composition rule and the code point edges.
	task automatic test_directed_rules();
		send_char(MODE_FLUSH, 16'hFFFF);  // flush with nothing held
		send_char(MODE_CHAR, 16'h3131);   // initial
		send_char(MODE_CHAR, 16'h314F);   // vowel makes an open syllable
		send_char(MODE_CHAR, 16'h3131);   // final
		send_char(MODE_CHAR, 16'h3145);   // compound final
		send_char(MODE_CHAR, 16'h3163);   // vowel splits a compound final
		send_char(MODE_CHAR, 16'h3134);   // final
		send_char(MODE_CHAR, 16'h3157);   // vowel moves a simple final
		send_char(MODE_CHAR, 16'h314F);   // compound vowel
		send_char(MODE_CHAR, 16'h3139);   // final
		send_char(MODE_CHAR, 16'h3138);   // consonant that is never a final
		send_char(MODE_CHAR, 16'h0041);   // non-jamo
		send_char(MODE_CHAR, 16'h314F);   // vowel after non-jamo
		send_char(MODE_CHAR, 16'hD7A3);   // last syllable typed directly
		send_char(MODE_CHAR, 16'h3163);   // vowel moves its final
		send_char(MODE_CHAR, 16'hAC00);   // first syllable typed directly
		send_char(MODE_CHAR, 16'h3163);   // vowel pair that does not combine
		send_char(MODE_CHAR, 16'hFFFF);
		send_char(MODE_CHAR, 16'h0000);
		send_char(MODE_CHAR, 16'h3130);   // just below the jamo range
		send_char(MODE_CHAR, 16'h3164);   // just above the jamo range
		send_char(MODE_CHAR, 16'hABFF);   // just below the syllable range
		send_char(MODE_FLUSH, 16'h5A5A);
		send_char(MODE_FLUSH, 16'h0000);  // second flush finds nothing held
		send_char(MODE_CHAR, 16'h314E);
		send_char(MODE_CHAR, 16'h3162);
	endtask

	// One typed word: initial, vowel, then maybe a compound vowel, finals, a stray jamo, a trailing vowel and a flush.
	task automatic send_word();
		int k;
		int v1;
		if ($urandom_range(1) == 0) begin
			k  = $urandom_range(6);
			v1 = vp_a[k];
		end else begin
			k  = -1;
			v1 = $urandom_range(20);
		end
		send_char(MODE_CHAR, lead_codes[$urandom_range(18)]);
		send_char(MODE_CHAR, 16'(VOW_BASE + v1));
		if (k >= 0 && $urandom_range(1) == 0)
			send_char(MODE_CHAR, 16'(VOW_BASE + vp_b[k]));
		if ($urandom_range(9) < 7) begin
			if ($urandom_range(1) == 0) begin
				k = $urandom_range(11);
				send_char(MODE_CHAR, tail_codes[fp_a[k]]);
				send_char(MODE_CHAR, tail_codes[fp_b[k]]);
			end else begin
				send_char(MODE_CHAR, tail_codes[$urandom_range(27, 1)]);
				if ($urandom_range(3) == 0)
					send_char(MODE_CHAR, 16'($urandom_range(32'h3162, 32'h3131)));
			end
		end
		if ($urandom_range(9) < 4)
			send_char(MODE_CHAR, 16'(VOW_BASE + $urandom_range(20)));
		if ($urandom_range(9) == 0)
			send_char(MODE_FLUSH, 16'($urandom()));
	endtask

	// Malformed or foreign input between words.
	task automatic send_noise();
		case ($urandom_range(5))
			0: send_char(MODE_CHAR, 16'($urandom()));
			1: send_char(MODE_CHAR, 16'($urandom_range(32'h3163, 32'h3131)));
			2: send_char(MODE_CHAR, 16'($urandom_range(32'hD7A3, 32'hAC00)));
			3: send_char(MODE_FLUSH, 16'($urandom()));
			4: send_char(MODE_CHAR, 16'(VOW_BASE + $urandom_range(20)));
			default: begin
				case ($urandom_range(3))
					0: send_char(MODE_CHAR, 16'h3130);
					1: send_char(MODE_CHAR, 16'h3164);
					2: send_char(MODE_CHAR, 16'hABFF);
					default: send_char(MODE_CHAR, 16'hD7A4);
				endcase
			end
		endcase
	endtask

	task automatic test_random_text(input int idle_pct, input int stall_pct, input int count);
		int stop_at;
		stop_at        = n_sent + count;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		while (n_sent < stop_at) begin
			if ($urandom_range(99) < 75)
				send_word();
			else
				send_noise();
		end
	endtask

	// Long receiver hold-off while the sender keeps going, then a full drain and three words.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 200;
		for (int i = 0; i < 30; i++)
			send_char(MODE_CHAR, 16'($urandom()));
		wait_drained();
		for (int i = 0; i < 3; i++)
			send_word();
	endtask

	// Pushes out whatever is still held and lets the pipeline settle.
	task automatic test_final_flush();
		send_idle_pct  = 0;
		recv_stall_pct = 20;
		send_char(MODE_FLUSH, 16'h0000);
		wait_drained();
		repeat (20) @(posedge clk);
	endtask

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = 16'h0000;
		s_axis_tuser   = MODE_CHAR;
		m_axis_tready  = 1'b0;
		held_code      = 16'h0000;
		held_busy      = 1'b0;
		exp_head       = 0;
		exp_tail       = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 0;
		n_sent         = 0;
		n_flushes      = 0;
		n_splits       = 0;
		n_received     = 0;
		n_errors       = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_rules();
		test_random_text(34, 82, 350);
		test_random_text(82, 34, 350);
		test_random_text(0, 0, 350);
		test_backpressure();
		test_final_flush();

		$display("Sent %0d transactions (%0d flushes), checked %0d output characters.",
			n_sent, n_flushes, n_received);
		$display("Syllable splits seen: %0d; mismatches: %0d.", n_splits, n_errors);
		if (n_errors == 0 && expected_count() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* hangul_jamo_composer_core.f */
rtl/hjc_pkg.sv
rtl/hjc_decode.sv
rtl/hjc_compose.sv
rtl/hangul_jamo_composer_core.sv
sim/testbench.sv
